### sv/pidaw_pkg.sv
`default_nettype none

package pidaw_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 24;
    localparam int DT_FRAC   = 24;
    localparam int DIV_DVD_W = 56;
    localparam int DIV_STEPS = 56;
    localparam int CFG_IDX_W = 3;

    typedef struct packed {
        logic signed [31:0] target;
        logic signed [31:0] sensed;
        logic [23:0]        step_time;
        logic               restart;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               limited;
    } out_item_t;

    typedef enum logic [2:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_DRIVE_FLOOR   = 3'd3,
        REG_DRIVE_CEILING = 3'd4,
        REG_ACCUM_FLOOR   = 3'd5,
        REG_ACCUM_CEILING = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_INC,
        ST_ACC,
        ST_MUL_I,
        ST_DIV_D,
        ST_WAIT_D,
        ST_MUL_D,
        ST_SUM,
        ST_CHECK,
        ST_LIMIT,
        ST_DIV_B,
        ST_WAIT_B,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_INC,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef enum logic {
        DIV_DERIV,
        DIV_BACK
    } div_src_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     cap_ediff;
        logic     cap_p;
        logic     cap_acc;
        logic     cap_i;
        logic     div_start;
        div_src_t div_src;
        logic     cap_deriv;
        logic     cap_d;
        logic     cap_sum;
        logic     cap_limit;
        logic     cap_back;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic dt_zero;
        logic back_needed;
        logic out_free;
    } status_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

    // Saturates a wide signed value to the 32-bit signal range.
    function automatic logic signed [31:0] sat_sig(input logic signed [33:0] x);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sd2147483647;
        lo = -34'sd2147483648;
        if (x > hi)
            return 32'sh7FFF_FFFF;
        else if (x < lo)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

    // Floor tested first: if limits cross, x < lo gives lo, else hi.
    function automatic logic signed [33:0] clamp(input logic signed [33:0] x,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
        if (x < 34'(lo))
            return 34'(lo);
        else if (x > 34'(hi))
            return 34'(hi);
        else
            return x;
    endfunction

    // Applies a sign to a magnitude, saturating to the signal range.
    function automatic logic signed [31:0] apply_sign(input logic neg,
                                                      input logic [47:0] m);
        logic [47:0] lim;
        logic [47:0] mm;
        lim = neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
        mm  = (m > lim) ? lim : m;
        return neg ? $signed(-mm[31:0]) : $signed(mm[31:0]);
    endfunction

endpackage

`default_nettype wire

### sv/pidaw_div.sv
`default_nettype none

module pidaw_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [55:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient,
    output logic             overflow
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [55:0] dvd_reg, dvd_next;
    logic [31:0] dvsr_reg, dvsr_next;
    logic [31:0] q_reg, q_next;
    logic        ovf_reg, ovf_next;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, dvd_reg[pidaw_pkg::DIV_DVD_W-1]};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvsr_next = dvsr_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dvsr_next = divisor;
            q_next    = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits in 32 bits.
            rem_next = fits ? 32'(trial - {1'b0, dvsr_reg}) : trial[31:0];
            dvd_next = {dvd_reg[pidaw_pkg::DIV_DVD_W-2:0], 1'b0};
            q_next   = {q_reg[30:0], fits};
            ovf_next = ovf_reg | q_reg[31];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(pidaw_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvsr_reg <= dvsr_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign overflow = ovf_reg;

endmodule

`default_nettype wire

### sv/pidaw_datapath.sv
`default_nettype none

module pidaw_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pidaw_pkg::cmd_t      cmd,
    output pidaw_pkg::status_t        status,
    input  wire pidaw_pkg::in_item_t  in_data,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    output pidaw_pkg::out_item_t      out_data,
    output logic                      out_valid,
    input  wire logic                 out_stall
);

    logic signed [31:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic signed [31:0] drive_floor_reg, drive_ceiling_reg;
    logic signed [31:0] accum_floor_reg, accum_ceiling_reg;

    logic signed [31:0] acc_reg, last_reg;
    logic signed [31:0] error_reg, ediff_reg;
    logic [23:0]        dt_reg;
    logic signed [31:0] p_reg, i_reg, d_reg, deriv_reg, drive_reg;
    logic signed [33:0] sum_reg;
    logic               limited_reg;
    logic               back_neg_reg;
    logic [63:0]        prod_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    pidaw_pkg::out_item_t out_reg;

    logic [31:0]        a_mag, b_mag;
    logic               neg_next;
    logic signed [31:0] inc;
    logic signed [31:0] acc_sat;
    logic signed [33:0] acc_clamped;
    logic signed [33:0] drive_clamped;
    logic               above, below;
    logic signed [33:0] back_x;
    logic [33:0]        back_mag;
    logic [55:0]        div_dvd;
    logic [31:0]        div_dvsr;
    logic               div_done;
    logic [31:0]        div_q;
    logic               div_ovf;
    logic [47:0]        div_mag;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            drive_floor_reg   <= 32'sh8000_0000;
            drive_ceiling_reg <= 32'sh7FFF_FFFF;
            accum_floor_reg   <= 32'sh8000_0000;
            accum_ceiling_reg <= 32'sh7FFF_FFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pidaw_pkg::REG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                pidaw_pkg::REG_INTEG_GAIN:    integ_gain_reg    <= cfg_data;
                pidaw_pkg::REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data;
                pidaw_pkg::REG_DRIVE_FLOOR:   drive_floor_reg   <= cfg_data;
                pidaw_pkg::REG_DRIVE_CEILING: drive_ceiling_reg <= cfg_data;
                pidaw_pkg::REG_ACCUM_FLOOR:   accum_floor_reg   <= cfg_data;
                pidaw_pkg::REG_ACCUM_CEILING: accum_ceiling_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Shared magnitude multiplier; the sign travels beside the product.
    always_comb
    begin
        case (cmd.mul_sel)
            pidaw_pkg::MUL_P:
            begin
                a_mag    = pidaw_pkg::mag32(prop_gain_reg);
                b_mag    = pidaw_pkg::mag32(error_reg);
                neg_next = prop_gain_reg[31] ^ error_reg[31];
            end
            pidaw_pkg::MUL_INC:
            begin
                a_mag    = pidaw_pkg::mag32(error_reg);
                b_mag    = {8'b0, dt_reg};
                neg_next = error_reg[31];
            end
            pidaw_pkg::MUL_I:
            begin
                a_mag    = pidaw_pkg::mag32(integ_gain_reg);
                b_mag    = pidaw_pkg::mag32(acc_reg);
                neg_next = integ_gain_reg[31] ^ acc_reg[31];
            end
            default:
            begin
                a_mag    = pidaw_pkg::mag32(deriv_gain_reg);
                b_mag    = pidaw_pkg::mag32(deriv_reg);
                neg_next = deriv_gain_reg[31] ^ deriv_reg[31];
            end
        endcase
    end

    assign inc     = pidaw_pkg::apply_sign(neg_reg, {8'b0, prod_reg[63:pidaw_pkg::DT_FRAC]});
    assign acc_sat = pidaw_pkg::sat_sig(34'(acc_reg) + 34'(inc));

    assign acc_clamped   = pidaw_pkg::clamp(34'(acc_sat), accum_floor_reg, accum_ceiling_reg);
    assign drive_clamped = pidaw_pkg::clamp(sum_reg, drive_floor_reg, drive_ceiling_reg);

    assign above = sum_reg > 34'(drive_ceiling_reg);
    assign below = sum_reg < 34'(drive_floor_reg);

    // Back-calculation: the accumulator becomes (drive - P - D) / ki.
    assign back_x   = 34'(drive_reg) - 34'(p_reg) - 34'(d_reg);
    assign back_mag = back_x[33] ? 34'(-back_x) : 34'(back_x);

    always_comb
    begin
        if (cmd.div_src == pidaw_pkg::DIV_BACK)
        begin
            div_dvd  = {6'b0, back_mag, 16'b0};
            div_dvsr = pidaw_pkg::mag32(integ_gain_reg);
        end
        else
        begin
            div_dvd  = {pidaw_pkg::mag32(ediff_reg), 24'b0};
            div_dvsr = {8'b0, dt_reg};
        end
    end

    assign div_mag = {15'b0, div_ovf, div_q};

    pidaw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvsr),
        .done     (div_done),
        .quotient (div_q),
        .overflow (div_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && in_data.restart)
            begin
                acc_reg  <= '0;
                last_reg <= '0;
            end
            if (cmd.cap_acc)
                acc_reg <= acc_clamped[31:0];
            if (cmd.cap_back)
                acc_reg <= pidaw_pkg::apply_sign(back_neg_reg, div_mag);
            if (cmd.load_out)
            begin
                last_reg      <= error_reg;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a_mag) * 64'(b_mag);
        neg_reg  <= neg_next;
        if (cmd.load)
        begin
            error_reg <= pidaw_pkg::sat_sig(34'(in_data.target) - 34'(in_data.sensed));
            dt_reg    <= in_data.step_time;
        end
        if (cmd.cap_ediff)
            ediff_reg <= pidaw_pkg::sat_sig(34'(error_reg) - 34'(last_reg));
        if (cmd.cap_p)
            p_reg <= pidaw_pkg::apply_sign(neg_reg, prod_reg[63:pidaw_pkg::FRAC_BITS]);
        if (cmd.cap_i)
            i_reg <= pidaw_pkg::apply_sign(neg_reg, prod_reg[63:pidaw_pkg::FRAC_BITS]);
        if (cmd.cap_d)
            d_reg <= pidaw_pkg::apply_sign(neg_reg, prod_reg[63:pidaw_pkg::FRAC_BITS]);
        if (cmd.cap_deriv)
            deriv_reg <= (dt_reg == '0) ? '0 : pidaw_pkg::apply_sign(ediff_reg[31], div_mag);
        if (cmd.cap_sum)
            sum_reg <= 34'(p_reg) + 34'(i_reg) + 34'(d_reg);
        if (cmd.cap_limit)
        begin
            drive_reg   <= drive_clamped[31:0];
            limited_reg <= above | below;
        end
        if (cmd.div_start && cmd.div_src == pidaw_pkg::DIV_BACK)
            back_neg_reg <= back_x[33] ^ integ_gain_reg[31];
        if (cmd.load_out)
        begin
            out_reg.drive   <= drive_reg;
            out_reg.limited <= limited_reg;
        end
    end

    assign status.div_done    = div_done;
    assign status.dt_zero     = (dt_reg == '0);
    assign status.back_needed = (integ_gain_reg != '0) &&
                                ((above && !error_reg[31] && error_reg != '0) ||
                                 (below && error_reg[31]));
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### sv/pidaw_ctrl.sv
`default_nettype none

module pidaw_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire pidaw_pkg::status_t status,
    output pidaw_pkg::cmd_t        cmd
);

    pidaw_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pidaw_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pidaw_pkg::ST_IDLE:    if (in_valid) state_next = pidaw_pkg::ST_MUL_P;
            pidaw_pkg::ST_MUL_P:   state_next = pidaw_pkg::ST_MUL_INC;
            pidaw_pkg::ST_MUL_INC: state_next = pidaw_pkg::ST_ACC;
            pidaw_pkg::ST_ACC:     state_next = pidaw_pkg::ST_MUL_I;
            pidaw_pkg::ST_MUL_I:   state_next = pidaw_pkg::ST_DIV_D;
            pidaw_pkg::ST_DIV_D:   state_next = pidaw_pkg::ST_WAIT_D;
            pidaw_pkg::ST_WAIT_D:
                if (status.div_done || status.dt_zero)
                    state_next = pidaw_pkg::ST_MUL_D;
            pidaw_pkg::ST_MUL_D:   state_next = pidaw_pkg::ST_SUM;
            pidaw_pkg::ST_SUM:     state_next = pidaw_pkg::ST_CHECK;
            pidaw_pkg::ST_CHECK:   state_next = pidaw_pkg::ST_LIMIT;
            pidaw_pkg::ST_LIMIT:
                state_next = status.back_needed ? pidaw_pkg::ST_DIV_B
                                                : pidaw_pkg::ST_FINISH;
            pidaw_pkg::ST_DIV_B:   state_next = pidaw_pkg::ST_WAIT_B;
            pidaw_pkg::ST_WAIT_B:
                if (status.div_done) state_next = pidaw_pkg::ST_FINISH;
            pidaw_pkg::ST_FINISH:
                if (status.out_free) state_next = pidaw_pkg::ST_IDLE;
            default:               state_next = pidaw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = pidaw_pkg::MUL_P;
        cmd.div_src = pidaw_pkg::DIV_DERIV;
        in_stall    = 1'b1;
        unique case (state_reg)
            pidaw_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            pidaw_pkg::ST_MUL_P:
            begin
                cmd.mul_sel   = pidaw_pkg::MUL_P;
                cmd.cap_ediff = 1'b1;
            end
            pidaw_pkg::ST_MUL_INC:
            begin
                cmd.mul_sel = pidaw_pkg::MUL_INC;
                cmd.cap_p   = 1'b1;
            end
            pidaw_pkg::ST_ACC:     cmd.cap_acc = 1'b1;
            pidaw_pkg::ST_MUL_I:   cmd.mul_sel = pidaw_pkg::MUL_I;
            pidaw_pkg::ST_DIV_D:
            begin
                cmd.cap_i     = 1'b1;
                cmd.div_start = !status.dt_zero;
            end
            pidaw_pkg::ST_WAIT_D:
                cmd.cap_deriv = status.div_done || status.dt_zero;
            pidaw_pkg::ST_MUL_D:   cmd.mul_sel = pidaw_pkg::MUL_D;
            pidaw_pkg::ST_SUM:     cmd.cap_d = 1'b1;
            pidaw_pkg::ST_CHECK:   cmd.cap_sum = 1'b1;
            pidaw_pkg::ST_LIMIT:   cmd.cap_limit = 1'b1;
            pidaw_pkg::ST_DIV_B:
            begin
                cmd.div_src   = pidaw_pkg::DIV_BACK;
                cmd.div_start = 1'b1;
            end
            pidaw_pkg::ST_WAIT_B:
            begin
                cmd.div_src  = pidaw_pkg::DIV_BACK;
                cmd.cap_back = status.div_done;
            end
            pidaw_pkg::ST_FINISH:  cmd.load_out = status.out_free;
            default: ;
        endcase
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pidaw_pkg::ST_IDLE && in_valid) |=> state_reg == pidaw_pkg::ST_MUL_P)
        else $error("accepted transfer did not start a step");

    a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == pidaw_pkg::ST_WAIT_D ||
                           state_reg == pidaw_pkg::ST_WAIT_B))
        else $error("divider started outside a wait sequence");

    a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (state_reg == pidaw_pkg::ST_IDLE && !cmd.load_out))
        else $error("result loaded twice for one step");

endmodule

`default_nettype wire

### sv/pid_controller_antiwindup_core.sv
`default_nettype none

// PID controller with a clamped integral and back-calculation anti-windup,
// Q16.16 signals and gains, step time in unsigned Q0.24 seconds. A step
// runs from the input transfer to the result through a state sequence that
// uses the bit-serial divider to form the derivative unless the step time is
// zero; a step whose drive saturates in the direction of the error with a
// nonzero integral gain runs the divider a second time for the
// back-calculated integral. A new step is accepted once the previous one is
// finished, while its result may still wait in the output register.
module pid_controller_antiwindup_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire pidaw_pkg::in_item_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pidaw_pkg::out_item_t      out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data
);

    pidaw_pkg::cmd_t    cmd;
    pidaw_pkg::status_t status;

    assign cfg_ready = 1'b1;

    pidaw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pidaw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

`default_nettype wire
